// ===== src/irlt_pkg.sv =====
package irlt_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 8;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_REPLACED  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_EXACT_HIT = 3'd3;
   localparam logic [2:0] ST_RANGE_HIT = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic                cmd;
      logic signed [63:0]  key_or_start;
      logic signed [63:0]  interval_end;
      logic [7:0]          new_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic [2:0] status;
   } rsp_type;

endpackage

// ===== src/interval_range_lookup_table.sv =====
// Interval table of up to 16 entries kept oldest first. A command is taken when start is
// high and busy is low; its single result word appears on rsp_data for exactly one cycle
// with rsp_strobe high, and the receiver cannot stall it, so it must take the word in that
// cycle. One comparator walks the stored entries, one per cycle, and the result strobes in the
// same cycle busy falls. An add that replaces the entry at position P (0 = oldest) then shifts
// the newer entries down one per cycle and writes the new entry. A new command may be started
// in the cycle the previous result strobes. The not-found value is written through csr_we /
// csr_wdata; the user must write it only while no command is in progress, which the block
// itself does not enforce.
module interval_range_lookup_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  irlt_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output irlt_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_WRITE
   } state_type;

   // entry storage, undefined until written
   logic signed [irlt_pkg::KEY_BITS-1:0]   entry_start_ff [irlt_pkg::ENTRIES];
   logic signed [irlt_pkg::KEY_BITS-1:0]   entry_end_ff   [irlt_pkg::ENTRIES];
   logic [irlt_pkg::VALUE_BITS-1:0]        entry_value_ff [irlt_pkg::ENTRIES];

   state_type                              state_ff, state_in;
   logic [irlt_pkg::CNT_BITS-1:0]          count_ff, count_in;
   logic [irlt_pkg::IDX_BITS-1:0]          idx_ff, idx_in;
   logic                                   cmd_ff, cmd_in;
   logic signed [irlt_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic signed [irlt_pkg::KEY_BITS-1:0]   end_ff, end_in;
   logic [irlt_pkg::VALUE_BITS-1:0]        val_ff, val_in;
   logic                                   exact_ff, exact_in;
   logic [irlt_pkg::IDX_BITS-1:0]          exact_idx_ff, exact_idx_in;
   logic [irlt_pkg::VALUE_BITS-1:0]        exact_val_ff, exact_val_in;
   logic                                   range_ff, range_in;
   logic [irlt_pkg::VALUE_BITS-1:0]        range_val_ff, range_val_in;
   logic [7:0]                             nf_value_ff;
   logic                                   rsp_strobe_ff, rsp_strobe_in;
   irlt_pkg::rsp_type                      rsp_ff, rsp_in;

   // single read port into the entry storage
   logic [irlt_pkg::IDX_BITS-1:0]          rd_idx;
   logic signed [irlt_pkg::KEY_BITS-1:0]   rd_start;
   logic signed [irlt_pkg::KEY_BITS-1:0]   rd_end;
   logic [irlt_pkg::VALUE_BITS-1:0]        rd_value;
   logic                                   hit_eq;
   logic                                   hit_range;

   // single write port
   logic                                   wr_en;
   logic [irlt_pkg::IDX_BITS-1:0]          wr_idx;
   logic signed [irlt_pkg::KEY_BITS-1:0]   wr_start;
   logic signed [irlt_pkg::KEY_BITS-1:0]   wr_end;
   logic [irlt_pkg::VALUE_BITS-1:0]        wr_value;

   logic [irlt_pkg::CNT_BITS-1:0]          last_cnt;
   logic [irlt_pkg::IDX_BITS-1:0]          last_idx;
   logic [irlt_pkg::IDX_BITS-1:0]          idx_next;

   assign last_cnt = count_ff - irlt_pkg::CNT_BITS'(1);
   assign last_idx = last_cnt[irlt_pkg::IDX_BITS-1:0];
   assign idx_next = idx_ff + irlt_pkg::IDX_BITS'(1);

   // shifting reads the newer neighbor
   assign rd_idx   = (state_ff == S_SHIFT) ? idx_next : idx_ff;
   assign rd_start = entry_start_ff[rd_idx];
   assign rd_end   = entry_end_ff[rd_idx];
   assign rd_value = entry_value_ff[rd_idx];

   // the shared compare unit
   assign hit_eq    = (rd_start == key_ff);
   assign hit_range = (rd_start <= key_ff) && (key_ff <= rd_end);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      end_in        = end_ff;
      val_in        = val_ff;
      exact_in      = exact_ff;
      exact_idx_in  = exact_idx_ff;
      exact_val_in  = exact_val_ff;
      range_in      = range_ff;
      range_val_in  = range_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_start      = key_ff;
      wr_end        = end_ff;
      wr_value      = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.cmd;
               key_in   = req_data.key_or_start[irlt_pkg::KEY_BITS-1:0];
               end_in   = req_data.interval_end[irlt_pkg::KEY_BITS-1:0];
               val_in   = req_data.new_value[irlt_pkg::VALUE_BITS-1:0];
               idx_in   = '0;
               exact_in = 1'b0;
               range_in = 1'b0;
               state_in = (count_ff == '0) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit_eq) begin
               exact_in     = 1'b1;
               exact_idx_in = idx_ff;
               exact_val_in = rd_value;
            end
            // ascending walk, so the last range hit is the newest
            if (hit_range) begin
               range_in     = 1'b1;
               range_val_in = rd_value;
            end
            if (idx_ff == last_idx) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_DECIDE: begin
            if (cmd_ff == irlt_pkg::CMD_LOOKUP) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (exact_ff) begin
                  rsp_in.read_value = 8'(exact_val_ff);
                  rsp_in.status     = irlt_pkg::ST_EXACT_HIT;
               end else if (range_ff) begin
                  rsp_in.read_value = 8'(range_val_ff);
                  rsp_in.status     = irlt_pkg::ST_RANGE_HIT;
               end else begin
                  rsp_in.read_value = nf_value_ff;
                  rsp_in.status     = irlt_pkg::ST_NOT_FOUND;
               end
            end else if (exact_ff) begin
               idx_in   = exact_idx_ff;
               state_in = (exact_idx_ff == last_idx) ? S_WRITE : S_SHIFT;
            end else if (count_ff == irlt_pkg::CNT_BITS'(irlt_pkg::ENTRIES)) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.read_value = '0;
               rsp_in.status     = irlt_pkg::ST_FULL;
               state_in          = S_IDLE;
            end else begin
               wr_en             = 1'b1;
               wr_idx            = count_ff[irlt_pkg::IDX_BITS-1:0];
               count_in          = count_ff + irlt_pkg::CNT_BITS'(1);
               rsp_strobe_in     = 1'b1;
               rsp_in.read_value = '0;
               rsp_in.status     = irlt_pkg::ST_ADDED;
               state_in          = S_IDLE;
            end
         end
         S_SHIFT: begin
            // close the gap left by the replaced entry
            wr_en    = 1'b1;
            wr_idx   = idx_ff;
            wr_start = rd_start;
            wr_end   = rd_end;
            wr_value = rd_value;
            idx_in   = idx_next;
            if (idx_next == last_idx) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en             = 1'b1;
            wr_idx            = last_idx;
            rsp_strobe_in     = 1'b1;
            rsp_in.read_value = '0;
            rsp_in.status     = irlt_pkg::ST_REPLACED;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         nf_value_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            nf_value_ff <= csr_wdata;
         end
      end
      idx_ff       <= idx_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      end_ff       <= end_in;
      val_ff       <= val_in;
      exact_ff     <= exact_in;
      exact_idx_ff <= exact_idx_in;
      exact_val_ff <= exact_val_in;
      range_ff     <= range_in;
      range_val_ff <= range_val_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_start_ff[wr_idx] <= wr_start;
         entry_end_ff[wr_idx]   <= wr_end;
         entry_value_ff[wr_idx] <= wr_value;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= irlt_pkg::CNT_BITS'(irlt_pkg::ENTRIES))
      else $error("entry count above table depth");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a command in progress");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_count_on_add: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && (count_ff != $past(count_ff)))
         |-> (rsp_strobe && rsp_data.status == irlt_pkg::ST_ADDED))
      else $error("entry count changed without an add");

   a_shift_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> ({1'b0, idx_ff} < last_cnt))
      else $error("shift ran past the newest entry");

endmodule
